>>> rtl/core/sha256_message_hasher_core_defines.svh
// Assertion macros used by the SHA-256 hasher back part.
`ifndef SHA256_MESSAGE_HASHER_CORE_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 hasher.
package sha_pkg;

  typedef logic [31:0] word_t;

  // Request from the front part to the back part.
  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } req_t;

  localparam int unsigned QDepth = 4;

  localparam word_t [0:7] HashInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t [0:63] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

>>> rtl/core/sha_front.sv
// Front part: input handshake and a short request queue toward the back part.
module sha_front
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       in_kind,
  input  logic [7:0] in_byte,
  output logic       q_valid,
  input  logic       q_pop,
  output req_t       q_head
);
  localparam int unsigned Aw = $clog2(QDepth);

  req_t              mem_r [QDepth];
  logic [Aw-1:0]     wp_r, rp_r;
  logic [Aw:0]       cnt_r;
  logic              push;

  // Accept requests while the queue has room.
  assign in_tready = (cnt_r != (Aw+1)'(QDepth));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_head    = mem_r[rp_r];

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{fin: in_kind, data: in_byte};
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (Aw+1)'(push) - (Aw+1)'(q_pop);
    end
  end

endmodule

>>> rtl/core/sha_back.sv
// Back part: block assembly, padding, 64-round compression and digest output.
module sha_back
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  req_t        q_head,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_word,
  output logic [2:0]  out_idx,
  output logic        out_last
);
`include "sha256_message_hasher_core_defines.svh"

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_ZERO, S_LEN, S_RUN, S_OUT} state_t;

  state_t        st_r;
  state_t        ret_r;      // where to go after a compression
  word_t [0:7]   h_r;
  word_t [0:7]   v_r;
  word_t [0:15]  w_r;        // message schedule window
  logic [5:0]    fill_r;
  logic [60:0]   total_r;
  logic [5:0]    rnd_r;
  logic [2:0]    oidx_r;
  logic          fin_r;      // compression is the final one of a message
  logic [2:0]    lenb_r;

  word_t         wnew, t1, t2, wcur;
  logic [63:0]   bits;

  assign bits = {total_r, 3'b000};
  assign wcur = w_r[0];
  assign wnew = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign t1   = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
              + RoundK[rnd_r] + wcur;
  assign t2   = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign q_pop      = (st_r == S_IDLE) && q_valid;
  assign out_tvalid = (st_r == S_OUT);
  assign out_word   = h_r[oidx_r];
  assign out_idx    = oidx_r;
  assign out_last   = (oidx_r == 3'd7);

  // Put one byte into the block window, big-endian within each word.
  function automatic word_t [0:15] put_byte(word_t [0:15] w, logic [5:0] pos,
                                            logic [7:0] b);
    word_t [0:15] r;
    r = w;
    r[pos[5:2]][8*(3-pos[1:0]) +: 8] = b;
    put_byte = r;
  endfunction

  // Sequencer for byte intake, padding, rounds and digest output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ret_r   <= S_IDLE;
      h_r     <= HashInit;
      fill_r  <= '0;
      total_r <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      lenb_r  <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            if (!q_head.fin) begin
              w_r     <= put_byte(w_r, fill_r, q_head.data);
              fill_r  <= fill_r + 1'b1;
              total_r <= total_r + 1'b1;
              if (fill_r == 6'd63) begin
                v_r   <= h_r;
                rnd_r <= '0;
                fin_r <= 1'b0;
                ret_r <= S_IDLE;
                st_r  <= S_RUN;
              end
            end else begin
              st_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          w_r    <= put_byte(w_r, fill_r, PadByte);
          fill_r <= fill_r + 1'b1;
          if (fill_r == 6'd63) begin
            v_r   <= h_r;
            rnd_r <= '0;
            fin_r <= 1'b0;
            ret_r <= S_ZERO;
            st_r  <= S_RUN;
          end else begin
            st_r <= S_ZERO;
          end
        end
        // Zero fill: if past the length field, to end of block and then to byte 56 of the next, else to byte 56.
        S_ZERO: begin
          if (fill_r == LenStart) begin
            lenb_r <= '0;
            st_r   <= S_LEN;
          end else begin
            w_r    <= put_byte(w_r, fill_r, 8'h00);
            fill_r <= fill_r + 1'b1;
            if (fill_r == 6'd63) begin
              v_r   <= h_r;
              rnd_r <= '0;
              fin_r <= 1'b0;
              ret_r <= S_ZERO;
              st_r  <= S_RUN;
            end
          end
        end
        S_LEN: begin
          w_r    <= put_byte(w_r, fill_r, bits[8*(7-lenb_r) +: 8]);
          fill_r <= fill_r + 1'b1;
          lenb_r <= lenb_r + 1'b1;
          if (lenb_r == 3'd7) begin
            v_r   <= h_r;
            rnd_r <= '0;
            fin_r <= 1'b1;
            st_r  <= S_RUN;
          end
        end
        // One round per cycle; the window shifts in the next schedule word.
        S_RUN: begin
          v_r   <= {t1 + t2, v_r[0], v_r[1], v_r[2], v_r[3] + t1, v_r[4], v_r[5], v_r[6]};
          w_r   <= {w_r[1:15], wnew};
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) begin
            // Fold the working variables after the last round into the hash.
            h_r[0] <= h_r[0] + t1 + t2;
            h_r[1] <= h_r[1] + v_r[0];
            h_r[2] <= h_r[2] + v_r[1];
            h_r[3] <= h_r[3] + v_r[2];
            h_r[4] <= h_r[4] + v_r[3] + t1;
            h_r[5] <= h_r[5] + v_r[4];
            h_r[6] <= h_r[6] + v_r[5];
            h_r[7] <= h_r[7] + v_r[6];
            if (fin_r) begin
              oidx_r <= '0;
              st_r   <= S_OUT;
            end else begin
              st_r <= ret_r;
            end
          end
        end
        S_OUT: begin
          if (out_tready) begin
            oidx_r <= oidx_r + 1'b1;
            if (oidx_r == 3'd7) begin
              h_r     <= HashInit;
              fill_r  <= '0;
              total_r <= '0;
              st_r    <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `SHA_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, st_r == S_IDLE)
  `SHA_ASSERT_NEXT(a_out_reset, clk, rst_n, out_tvalid && out_tready && out_last, fill_r == 6'd0 && total_r == '0)
  `SHA_ASSERT_NEXT(a_run_holds, clk, rst_n, st_r == S_RUN && rnd_r != 6'd63, st_r == S_RUN)
  `SHA_ASSERT_IMP(a_len_aligned, clk, rst_n, st_r == S_LEN, fill_r[5:3] == 3'b111)

endmodule

>>> rtl/core/sha256_message_hasher_core.sv
// A data byte is taken by the back part; one that completes a block starts the
// compression. A finish request runs padding, the length field and the compression,
// with an extra block when more than 55 bytes are held, then eight digest words, one a
// cycle while out_tready is high. The 64-round compression, one round per cycle, sets
// the rate; a 4-entry queue absorbs input while it runs. Synchronous active-low reset
// restores the initial hash. Top level of the SHA-256 message hasher.
module sha256_message_hasher_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word[31:0]
  output logic [2:0]  out_tuser,  // word_index[2:0]
  output logic        out_tlast   // last_word
);
  logic q_valid, q_pop;
  req_t q_head;

  sha_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_kind(in_tuser), .in_byte(in_tdata),
    .q_valid, .q_pop, .q_head
  );

  sha_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_head,
    .out_tvalid, .out_tready,
    .out_word(out_tdata), .out_idx(out_tuser), .out_last(out_tlast)
  );

endmodule
